// ----- rtl/core/fppl_pkg.sv -----
// foot plant position lock: shared constants, register indexes and mode codes
package fppl_pkg;

  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOW       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_HIGH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_RADIUS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SPEED    = 3'd4;

  localparam logic [30:0] WEIGHT_THRESHOLD_RST = 31'(64'd1 << FRAC_BITS);
  localparam logic [31:0] HEIGHT_LOW_RST       = 32'(64'd1 << (FRAC_BITS - 1));
  localparam logic [31:0] HEIGHT_HIGH_RST      = 32'(((64'd6 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [30:0] HOLD_RADIUS_RST      = 31'(64'd1 << (FRAC_BITS - 3));
  localparam logic [30:0] RELEASE_SPEED_RST    = 31'(64'd25 << FRAC_BITS);

  // release step is delta time (16 bits once clamped) times speed (31 bits), rescaled
  localparam int unsigned STEP_W = 47 - FRAC_BITS;
  localparam int unsigned GAP_W  = ((STEP_W > 33) ? STEP_W : 33) + 2;

  typedef enum logic [1:0] {
    MODE_FREE    = 2'd0,
    MODE_PLANTED = 2'd1,
    MODE_RELEASE = 2'd2
  } lock_mode_e;

endpackage

// ----- rtl/core/foot_plant_position_lock.sv -----
// foot plant position lock: sequencer around one multiplier and one shared subtractor
//
// Input requests arrive on in_valid_i / in_stall_o; one request is taken when valid is
// high and stall is low. Results leave on out_valid_o / out_stall_i under the same rule.
// Registers are written through cfg_valid_i / cfg_ready_o with an index and data word;
// the user must do so only while no request is in flight, as the block does not check.
// cfg_ready_o is always high. One request is worked on at a time and in_stall_o is high
// until its result has been moved into the output register. Work from accept to result:
//   free, or plant starting: the decision only
//   planted within the hold radius, or release reaching the point: the square root
//   planted clamp or partial release: the square root, then two 32 step divisions
// The 33 step square root and the two 32 step divisions all run on the same subtractor.
// A new request is taken while a finished result still waits on
// out_stall_i; the next result then waits in the sequencer until the output register
// is free. Reset clears the registers to their defaults, the mode to free and the
// anchor, last output and gap to zero; no result is pending after reset.
module foot_plant_position_lock (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fppl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fppl_pkg::DATA_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [31:0]                point_x_i,
  input  logic signed [31:0]                point_y_i,
  input  logic signed [31:0]                point_z_i,
  input  logic signed [31:0]                weight_value_i,
  input  logic signed [16:0]                delta_time_i,
  input  logic                              restart_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [31:0]                out_x_o,
  output logic signed [31:0]                out_y_o,
  output logic signed [31:0]                out_z_o,
  output logic [1:0]                        mode_o
);
  import fppl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_ADD,
    ST_SQRT,
    ST_LEN,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_APPLY,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_CLAMP,
    PH_REL_START,
    PH_REL
  } phase_e;

  // configuration
  logic [30:0] thr_q;
  logic [31:0] hlow_q;
  logic [31:0] hhigh_q;
  logic [30:0] radius_q;
  logic [30:0] speed_q;

  // lock state
  lock_mode_e  mode_q;
  logic [31:0] anchor_x_q;
  logic [31:0] anchor_y_q;
  logic [31:0] last_x_q;
  logic [31:0] last_y_q;
  logic [30:0] gap_q;

  // request and work registers
  state_e      state_q;
  phase_e      phase_q;
  logic [31:0] px_q;
  logic [31:0] py_q;
  logic [31:0] pz_q;
  logic [31:0] w_q;
  logic [15:0] dt_q;
  logic        restart_q;
  logic        plant_q;
  lock_mode_e  wmode_q;
  logic        set_anchor_q;
  logic        gap_we_q;
  logic [30:0] gnew_q;
  logic [31:0] base_x_q;
  logic [31:0] base_y_q;
  logic [31:0] mag_x_q;
  logic [31:0] mag_y_q;
  logic        neg_x_q;
  logic        neg_y_q;
  logic        axis_q;
  logic [31:0] res_x_q;
  logic [31:0] res_y_q;
  logic [63:0] prod_q;
  logic [65:0] rad_q;
  logic [34:0] rem_q;
  logic [32:0] root_q;
  logic [31:0] qr_q;
  logic [32:0] num_q;
  logic [5:0]  cnt_q;

  // output register
  logic        out_valid_q;
  logic [31:0] out_x_q;
  logic [31:0] out_y_q;
  logic [31:0] out_z_q;
  lock_mode_e  out_mode_q;

  // decide
  lock_mode_e  cur_mode;
  logic        heavy;
  logic [31:0] lim;
  logic        plant;
  logic [31:0] bx;
  logic [31:0] by;
  logic [32:0] dx;
  logic [32:0] dy;

  // shared units
  logic [31:0] cur_mag;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [36:0] sub_a;
  logic [36:0] sub_b;
  logic [37:0] sub_diff;
  logic        sub_ge;

  // length stage
  logic [STEP_W-1:0]       step;
  logic [30:0]             gl;
  logic signed [GAP_W-1:0] g0;
  logic signed [GAP_W-1:0] len_ext;
  logic signed [GAP_W-1:0] g;
  logic                    g_pos;

  logic [31:0] q_res;
  logic        in_acc;
  logic        out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign mode_o      = out_mode_q;

  always_comb begin
    cur_mode = restart_q ? MODE_FREE : mode_q;
    heavy    = $signed(w_q) >= $signed({1'b0, thr_q});
    lim      = (cur_mode == MODE_PLANTED) ? hhigh_q : hlow_q;
    plant    = heavy ? ($signed(lim) > $signed(pz_q)) : 1'b1;
    bx       = (cur_mode == MODE_PLANTED && plant) ? anchor_x_q : last_x_q;
    by       = (cur_mode == MODE_PLANTED && plant) ? anchor_y_q : last_y_q;
    dx       = {px_q[31], px_q} - {bx[31], bx};
    dy       = {py_q[31], py_q} - {by[31], by};
  end

  assign cur_mag = axis_q ? mag_y_q : mag_x_q;

  always_comb begin
    case (state_q)
      ST_SQ_X: begin
        mul_a = mag_x_q;
        mul_b = mag_x_q;
      end
      ST_SQ_Y: begin
        mul_a = mag_y_q;
        mul_b = mag_y_q;
      end
      ST_SQ_ADD: begin
        mul_a = {16'd0, dt_q};
        mul_b = {1'b0, speed_q};
      end
      default: begin
        mul_a = cur_mag;
        mul_b = num_q[31:0];
      end
    endcase
  end

  // trial subtract: root digit in the square root, quotient bit in the division
  always_comb begin
    if (state_q == ST_SQRT) begin
      sub_a = {rem_q[34:0], rad_q[65:64]};
      sub_b = {2'b00, root_q, 2'b01};
    end else begin
      sub_a = {3'b000, rem_q[32:0], qr_q[31]};
      sub_b = {4'b0000, root_q};
    end
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge   = !sub_diff[37];
  end

  always_comb begin
    step    = prod_q[FRAC_BITS +: STEP_W];
    gl      = (phase_q == PH_REL_START) ? ((|root_q[32:31]) ? 31'h7FFF_FFFF : root_q[30:0])
                                        : gap_q;
    len_ext = $signed({{(GAP_W-33){1'b0}}, root_q});
    g0      = $signed({{(GAP_W-31){1'b0}}, gl}) - $signed({{(GAP_W-STEP_W){1'b0}}, step});
    g       = (g0 > len_ext) ? len_ext : g0;
    g_pos   = !g[GAP_W-1] && (g != '0);
  end

  always_comb begin
    if (axis_q) begin
      q_res = neg_y_q ? (base_y_q - qr_q) : (base_y_q + qr_q);
    end else begin
      q_res = neg_x_q ? (base_x_q - qr_q) : (base_x_q + qr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= WEIGHT_THRESHOLD_RST;
      hlow_q   <= HEIGHT_LOW_RST;
      hhigh_q  <= HEIGHT_HIGH_RST;
      radius_q <= HOLD_RADIUS_RST;
      speed_q  <= RELEASE_SPEED_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WEIGHT_THRESHOLD: thr_q    <= cfg_data_i[30:0];
        REG_HEIGHT_LOW:       hlow_q   <= cfg_data_i;
        REG_HEIGHT_HIGH:      hhigh_q  <= cfg_data_i;
        REG_HOLD_RADIUS:      radius_q <= cfg_data_i[30:0];
        REG_RELEASE_SPEED:    speed_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_CLAMP;
      mode_q       <= MODE_FREE;
      anchor_x_q   <= '0;
      anchor_y_q   <= '0;
      last_x_q     <= '0;
      last_y_q     <= '0;
      gap_q        <= '0;
      px_q         <= '0;
      py_q         <= '0;
      pz_q         <= '0;
      w_q          <= '0;
      dt_q         <= '0;
      restart_q    <= 1'b0;
      plant_q      <= 1'b0;
      wmode_q      <= MODE_FREE;
      set_anchor_q <= 1'b0;
      gap_we_q     <= 1'b0;
      gnew_q       <= '0;
      base_x_q     <= '0;
      base_y_q     <= '0;
      mag_x_q      <= '0;
      mag_y_q      <= '0;
      neg_x_q      <= 1'b0;
      neg_y_q      <= 1'b0;
      axis_q       <= 1'b0;
      res_x_q      <= '0;
      res_y_q      <= '0;
      prod_q       <= '0;
      rad_q        <= '0;
      rem_q        <= '0;
      root_q       <= '0;
      qr_q         <= '0;
      num_q        <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_z_q      <= '0;
      out_mode_q   <= MODE_FREE;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            px_q      <= point_x_i;
            py_q      <= point_y_i;
            pz_q      <= point_z_i;
            w_q       <= weight_value_i;
            dt_q      <= delta_time_i[16] ? 16'd0 : delta_time_i[15:0];
            restart_q <= restart_i;
            state_q   <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          plant_q      <= plant;
          res_x_q      <= px_q;
          res_y_q      <= py_q;
          set_anchor_q <= 1'b0;
          gap_we_q     <= 1'b0;
          wmode_q      <= cur_mode;
          base_x_q     <= bx;
          base_y_q     <= by;
          neg_x_q      <= dx[32];
          neg_y_q      <= dy[32];
          mag_x_q      <= dx[32] ? (~dx[31:0] + 32'd1) : dx[31:0];
          mag_y_q      <= dy[32] ? (~dy[31:0] + 32'd1) : dy[31:0];
          case (cur_mode)
            MODE_FREE: begin
              if (plant) begin
                set_anchor_q <= 1'b1;
                wmode_q      <= MODE_PLANTED;
              end
              state_q <= ST_FIN;
            end
            MODE_PLANTED: begin
              if (plant) begin
                phase_q <= PH_CLAMP;
              end else begin
                phase_q <= PH_REL_START;
                wmode_q <= MODE_RELEASE;
              end
              state_q <= ST_SQ_X;
            end
            MODE_RELEASE: begin
              phase_q <= PH_REL;
              state_q <= ST_SQ_X;
            end
            default: state_q <= ST_FIN;
          endcase
        end
        ST_SQ_X: begin
          prod_q  <= mul_a * mul_b;
          state_q <= ST_SQ_Y;
        end
        ST_SQ_Y: begin
          rad_q   <= {2'b00, prod_q};
          prod_q  <= mul_a * mul_b;
          state_q <= ST_SQ_ADD;
        end
        ST_SQ_ADD: begin
          rad_q   <= rad_q + {2'b00, prod_q};
          prod_q  <= mul_a * mul_b;
          rem_q   <= '0;
          root_q  <= '0;
          cnt_q   <= 6'd32;
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          rem_q  <= sub_ge ? sub_diff[34:0] : sub_a[34:0];
          root_q <= {root_q[31:0], sub_ge};
          rad_q  <= {rad_q[63:0], 2'b00};
          cnt_q  <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            state_q <= ST_LEN;
          end
        end
        ST_LEN: begin
          axis_q <= 1'b0;
          if (phase_q == PH_CLAMP) begin
            num_q <= {2'b00, radius_q};
            if (root_q > {2'b00, radius_q}) begin
              state_q <= ST_MUL;
            end else begin
              state_q <= ST_FIN;
            end
          end else begin
            gap_we_q     <= 1'b1;
            set_anchor_q <= plant_q;
            if (g_pos) begin
              num_q   <= root_q - g[32:0];
              gnew_q  <= g[30:0];
              wmode_q <= plant_q ? MODE_PLANTED : MODE_RELEASE;
              state_q <= ST_MUL;
            end else begin
              gnew_q  <= '0;
              wmode_q <= plant_q ? MODE_PLANTED : MODE_FREE;
              state_q <= ST_FIN;
            end
          end
        end
        ST_MUL: begin
          prod_q  <= mul_a * mul_b;
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          rem_q   <= {2'b00, {1'b0, prod_q[63:32]} + (num_q[32] ? {1'b0, cur_mag} : 33'd0)};
          qr_q    <= prod_q[31:0];
          cnt_q   <= 6'd31;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= sub_ge ? sub_diff[34:0] : sub_a[34:0];
          qr_q  <= {qr_q[30:0], sub_ge};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (axis_q) begin
            res_y_q <= q_res;
            state_q <= ST_FIN;
          end else begin
            res_x_q <= q_res;
            axis_q  <= 1'b1;
            state_q <= ST_MUL;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_x_q     <= res_x_q;
            out_y_q     <= res_y_q;
            out_z_q     <= pz_q;
            out_mode_q  <= wmode_q;
            mode_q      <= wmode_q;
            last_x_q    <= res_x_q;
            last_y_q    <= res_y_q;
            if (set_anchor_q) begin
              anchor_x_q <= res_x_q;
              anchor_y_q <= res_y_q;
            end
            if (gap_we_q) begin
              gap_q <= gnew_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // releasing always carries a gap still to close
  a_release_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_RELEASE) |-> (gap_q != '0))
    else $error("release mode with zero gap");

  // square root remainder stays within twice the partial root
  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (rem_q <= {1'b0, root_q, 1'b0}))
    else $error("square root remainder out of range");

  // scaled offset never exceeds the offset it came from
  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == '0) |=> (qr_q <= $past(cur_mag)))
    else $error("scaled offset larger than offset");

endmodule
